// ----- rtl/core/atm_pkg.sv -----
package atm_pkg;

  localparam int NUM_ALARMS  = 8;
  localparam int IDX_W       = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;

  localparam int HOUR_W      = 5;
  localparam int MINUTE_W    = 6;
  localparam int MASK_W      = 7;
  localparam int WDAY_W      = 3;
  localparam int ENTRY_W     = 3;
  localparam int MOD_W       = 11;
  localparam int DELAY_W     = 11;
  localparam int SUM_W       = 12;

  localparam int MIN_PER_HOUR = 60;
  localparam int MIN_PER_DAY  = 24 * 60;
  localparam int DELAY_RESET  = 9;

  // floor(x / 60) == (x * 1093) >> 16 for every x below one day
  localparam int RECIP_60     = 1093;
  localparam int RECIP_SHIFT  = 16;
  localparam int PROD_W       = MOD_W + 11;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_ARM   = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    FIRE_NONE   = 2'd0,
    FIRE_ALARM  = 2'd1,
    FIRE_SNOOZE = 2'd2
  } fire_t;

  typedef struct packed {
    opcode_t               opcode;
    logic [WDAY_W-1:0]     weekday;
    logic [HOUR_W-1:0]     hour;
    logic [MINUTE_W-1:0]   minute;
    logic [ENTRY_W-1:0]    entry_index;
    logic                  entry_enable;
    logic [MASK_W-1:0]     day_mask;
  } item_t;

  typedef struct packed {
    logic                  enable;
    logic [HOUR_W-1:0]     hour;
    logic [MINUTE_W-1:0]   minute;
    logic [MASK_W-1:0]     mask;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic fire_snooze;
    logic scan;
    logic write_entry;
    logic snz_sum;
    logic snz_reduce;
    logic snz_hour;
    logic snz_min;
    logic snz_clear;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_t opcode;
    logic    last_hit;
    logic    due;
    logic    scan_hit;
    logic    scan_last;
    logic    sum_ge;
    logic    out_busy;
  } stat_t;

endpackage

// ----- rtl/core/alarm_table_matcher.sv -----
// alarm table matcher
// in channel: one transfer per command. tuser holds the opcode (tick, write
// entry, arm snooze, clear snooze), tdata the time, entry and mask fields.
// out channel: exactly one result transfer per command, in command order.
// cfg channel: writes the snooze delay in minutes, taken only while idle.
// processing from input transfer to result valid:
//   a tick with no scan (same minute or snooze due), write and clear need no
//   further step before the result; a tick that scans the table checks one
//   entry per cycle up to the first hit; arm snooze subtracts one day per
//   cycle while the sum is a day or more, then takes an hour and a minute step.
// the controller handles one command at a time and in_tready is high only
// while it is idle.
// the result register holds one finished result, so the next command is
// taken while a result waits; if out_tready stays low the following result
// waits in the controller and in_tready stays low.
// reset (rst_n low, synchronous): all entries disabled and zeroed, snooze
// off, no minute fired yet, snooze delay 9; no result pending.
module alarm_table_matcher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // weekday[2:0] hour[7:3] minute[13:8]
                                  // entry_index[16:14] entry_enable[17]
                                  // day_mask[24:18], zero above
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // fired_entry[2:0] snooze_due_now[3]
                                  // snooze_pending[4], zero above
  output logic [1:0]  out_tuser,  // fire_kind[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data    // snooze_delay[10:0]
);
  import atm_pkg::*;

  item_t              in_item;
  cmd_t               cmd;
  stat_t              stat;
  fire_t              out_kind;
  logic [ENTRY_W-1:0] out_entry;
  logic               out_due;
  logic               out_pending;

  // delay writes only while the controller is idle
  assign cfg_ready = in_tready;

  assign in_item = '{opcode:       opcode_t'(in_tuser),
                     weekday:      in_tdata[2:0],
                     hour:         in_tdata[7:3],
                     minute:       in_tdata[13:8],
                     entry_index:  in_tdata[16:14],
                     entry_enable: in_tdata[17],
                     day_mask:     in_tdata[24:18]};

  atm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  atm_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_item),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_kind    (out_kind),
    .out_entry   (out_entry),
    .out_due     (out_due),
    .out_pending (out_pending)
  );

  assign out_tuser = out_kind;
  assign out_tdata = {3'b000, out_pending, out_due, out_entry};

  // one command in flight: no second transfer right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a command is in flight");

  // a snooze can only fire when it was due, and it is gone afterwards
  a_snooze_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == FIRE_SNOOZE)) |-> (out_tdata[3] && !out_tdata[4]))
    else $error("snooze fired without being due or left pending");

  // an entry number only comes with a fired alarm
  a_entry_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[2:0] != 3'd0)) |-> (out_tuser == FIRE_ALARM))
    else $error("entry number reported without an alarm");

endmodule

// ----- rtl/core/atm_ctrl.sv -----
module atm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  atm_pkg::stat_t stat,
  output atm_pkg::cmd_t  cmd
);
  import atm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_REDUCE,
    S_HOUR,
    S_MIN,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   ready_r, ready_nxt;

  always_comb begin
    state_nxt = state_r;
    ready_nxt = ready_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && ready_r) begin
          cmd.load  = 1'b1;
          ready_nxt = 1'b0;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.opcode)
          OP_TICK: begin
            if (stat.last_hit) begin
              state_nxt = S_EMIT;
            end else if (stat.due) begin
              cmd.fire_snooze = 1'b1;
              state_nxt       = S_EMIT;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          OP_WRITE: begin
            cmd.write_entry = 1'b1;
            state_nxt       = S_EMIT;
          end
          OP_ARM: begin
            cmd.snz_sum = 1'b1;
            state_nxt   = S_REDUCE;
          end
          default: begin
            cmd.snz_clear = 1'b1;
            state_nxt     = S_EMIT;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_hit || stat.scan_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_REDUCE: begin
        // at most two subtractions of a full day
        if (stat.sum_ge) begin
          cmd.snz_reduce = 1'b1;
        end else begin
          state_nxt = S_HOUR;
        end
      end
      S_HOUR: begin
        cmd.snz_hour = 1'b1;
        state_nxt    = S_MIN;
      end
      S_MIN: begin
        cmd.snz_min = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          ready_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        ready_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ready_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      ready_r <= ready_nxt;
    end
  end

  assign in_ready = ready_r;

endmodule

// ----- rtl/core/atm_datapath.sv -----
module atm_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  atm_pkg::item_t                in_item,
  input  logic                          cfg_we,
  input  logic [atm_pkg::DELAY_W-1:0]   cfg_data,
  input  atm_pkg::cmd_t                 cmd,
  output atm_pkg::stat_t                stat,
  input  logic                          out_ready,
  output logic                          out_valid,
  output atm_pkg::fire_t                out_kind,
  output logic [atm_pkg::ENTRY_W-1:0]   out_entry,
  output logic                          out_due,
  output logic                          out_pending
);
  import atm_pkg::*;

  item_t                 item_r;
  logic                  due_r;
  logic [IDX_W-1:0]      scan_r;
  fire_t                 kind_r;
  logic [ENTRY_W-1:0]    fired_r;
  logic [MOD_W-1:0]      last_min_r;
  logic                  last_valid_r;
  logic                  snz_active_r;
  logic [HOUR_W-1:0]     snz_hour_r;
  logic [MINUTE_W-1:0]   snz_minute_r;
  logic [DELAY_W-1:0]    delay_r;
  logic [SUM_W-1:0]      sum_r;
  entry_t                entry_r [NUM_ALARMS];

  logic                  out_valid_r;
  fire_t                 out_kind_r;
  logic [ENTRY_W-1:0]    out_entry_r;
  logic                  out_due_r;
  logic                  out_pending_r;

  logic [MOD_W-1:0]      hour_ext;
  logic [MOD_W-1:0]      mod_of_day;
  logic                  due_now;
  entry_t                cur;
  logic [MASK_W:0]       mask_shift;
  logic                  day_ok;
  logic                  scan_hit;
  logic [PROD_W-1:0]     prod;
  logic [HOUR_W-1:0]     hour_calc;
  logic [MOD_W-1:0]      min_full;

  // hour*60 + minute, never reduced
  assign hour_ext   = MOD_W'(item_r.hour);
  assign mod_of_day = (hour_ext << 6) - (hour_ext << 2) + MOD_W'(item_r.minute);

  assign due_now = snz_active_r && (in_item.hour == snz_hour_r) &&
                   (in_item.minute == snz_minute_r);

  assign cur        = entry_r[scan_r];
  // weekday seven shifts in the zero on top and selects nothing
  assign mask_shift = {1'b0, cur.mask} >> item_r.weekday;
  assign day_ok     = (cur.mask == '0) || mask_shift[0];
  assign scan_hit   = cur.enable && (cur.hour == item_r.hour) &&
                      (cur.minute == item_r.minute) && day_ok;

  assign prod      = PROD_W'(sum_r[MOD_W-1:0]) * PROD_W'(RECIP_60);
  assign hour_calc = prod[RECIP_SHIFT +: HOUR_W];
  assign min_full  = sum_r[MOD_W-1:0] - MOD_W'(snz_hour_r) * MOD_W'(MIN_PER_HOUR);

  always_comb begin
    stat           = '0;
    stat.opcode    = item_r.opcode;
    stat.last_hit  = last_valid_r && (mod_of_day == last_min_r);
    stat.due       = due_r;
    stat.scan_hit  = scan_hit;
    stat.scan_last = (scan_r == IDX_W'(NUM_ALARMS - 1));
    stat.sum_ge    = (sum_r >= SUM_W'(MIN_PER_DAY));
    stat.out_busy  = out_valid_r && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
      due_r  <= due_now;
    end
    if (cmd.snz_sum) begin
      sum_r <= SUM_W'(mod_of_day) + SUM_W'(delay_r);
    end else if (cmd.snz_reduce) begin
      sum_r <= sum_r - SUM_W'(MIN_PER_DAY);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r       <= '0;
      kind_r       <= FIRE_NONE;
      fired_r      <= '0;
      last_min_r   <= '0;
      last_valid_r <= 1'b0;
      snz_active_r <= 1'b0;
      snz_hour_r   <= '0;
      snz_minute_r <= '0;
      delay_r      <= DELAY_W'(DELAY_RESET);
      for (int i = 0; i < NUM_ALARMS; i++) begin
        entry_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        delay_r <= cfg_data;
      end
      if (cmd.load) begin
        scan_r  <= '0;
        kind_r  <= FIRE_NONE;
        fired_r <= '0;
      end
      if (cmd.fire_snooze) begin
        last_min_r   <= mod_of_day;
        last_valid_r <= 1'b1;
        snz_active_r <= 1'b0;
        kind_r       <= FIRE_SNOOZE;
      end
      if (cmd.scan) begin
        if (scan_hit) begin
          last_min_r   <= mod_of_day;
          last_valid_r <= 1'b1;
          kind_r       <= FIRE_ALARM;
          fired_r      <= ENTRY_W'(scan_r);
          // one-off entries switch themselves off
          if (cur.mask == '0) begin
            entry_r[scan_r].enable <= 1'b0;
          end
        end else begin
          scan_r <= scan_r + 1'b1;
        end
      end
      if (cmd.write_entry && (int'(item_r.entry_index) < NUM_ALARMS)) begin
        entry_r[IDX_W'(item_r.entry_index)] <= '{enable: item_r.entry_enable,
                                                 hour:   item_r.hour,
                                                 minute: item_r.minute,
                                                 mask:   item_r.day_mask};
      end
      if (cmd.snz_hour) begin
        snz_hour_r <= hour_calc;
      end
      if (cmd.snz_min) begin
        snz_minute_r <= min_full[MINUTE_W-1:0];
        snz_active_r <= 1'b1;
      end
      if (cmd.snz_clear) begin
        snz_active_r <= 1'b0;
      end
    end
  end

  // result register, lets the next item in while a result waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r    <= kind_r;
      out_entry_r   <= fired_r;
      out_due_r     <= due_r;
      out_pending_r <= snz_active_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_entry   = out_entry_r;
  assign out_due     = out_due_r;
  assign out_pending = out_pending_r;

endmodule

// ----- bench/atm_fire_checker.sv -----
`timescale 1ns / 100ps

module atm_fire_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // weekday[2:0] hour[7:3] minute[13:8]
                                  // entry_index[16:14] entry_enable[17]
                                  // day_mask[24:18], zero above
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // fired_entry[2:0] snooze_due_now[3]
                                  // snooze_pending[4], zero above
  input  logic [1:0]  out_tuser,  // fire_kind[1:0]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [10:0] cfg_data,   // snooze_delay[10:0]
  output int          fail_count,
  output int          pending
);

  import atm_pkg::*;

  typedef struct packed {
    fire_t           kind;
    logic [IDX_W-1:0] entry;
    logic            due;
    logic            snz_armed;
  } fire_result_t;

  entry_t              alarms [NUM_ALARMS];
  logic [MOD_W-1:0]    fired_minute;
  logic                fired_valid;
  logic                snz_on;
  logic [HOUR_W-1:0]   snz_hour;
  logic [MINUTE_W-1:0] snz_minute;
  logic [DELAY_W-1:0]  delay;
  fire_result_t        fire_q [$];
  int                  mismatches = 0;

  assign fail_count = mismatches;

  // one command against the shadow alarm state, returns the result it causes
  function automatic fire_result_t predict_fire(item_t c);
    fire_result_t r;
    logic [MOD_W-1:0] mod;
    logic hit;
    logic day_ok;
    int total;
    int i;
    r.kind = FIRE_NONE;
    r.entry = '0;
    r.due = snz_on && c.hour == snz_hour && c.minute == snz_minute;
    hit = 1'b0;
    case (c.opcode)
      OP_TICK: begin
        mod = MOD_W'(c.hour * MIN_PER_HOUR + c.minute);
        // one event per minute of day at most
        if (!(fired_valid && mod == fired_minute)) begin
          if (r.due) begin
            fired_minute = mod;
            fired_valid = 1'b1;
            snz_on = 1'b0;
            r.kind = FIRE_SNOOZE;
          end else begin
            for (i = 0; i < NUM_ALARMS; i++) begin
              // weekday seven shifts the mask to nothing
              day_ok = (alarms[i].mask == '0) || (((alarms[i].mask >> c.weekday) & 7'd1) != '0);
              if (!hit && alarms[i].enable && alarms[i].hour == c.hour &&
                  alarms[i].minute == c.minute && day_ok) begin
                hit = 1'b1;
                fired_minute = mod;
                fired_valid = 1'b1;
                if (alarms[i].mask == '0) alarms[i].enable = 1'b0;
                r.kind = FIRE_ALARM;
                r.entry = IDX_W'(i);
              end
            end
          end
        end
      end
      OP_WRITE: begin
        if (c.entry_index < NUM_ALARMS) begin
          alarms[c.entry_index].enable = c.entry_enable;
          alarms[c.entry_index].hour = c.hour;
          alarms[c.entry_index].minute = c.minute;
          alarms[c.entry_index].mask = c.day_mask;
        end
      end
      OP_ARM: begin
        total = (c.hour * MIN_PER_HOUR + c.minute + delay) % MIN_PER_DAY;
        snz_hour = HOUR_W'(total / MIN_PER_HOUR);
        snz_minute = MINUTE_W'(total % MIN_PER_HOUR);
        snz_on = 1'b1;
      end
      default: begin
        snz_on = 1'b0;
      end
    endcase
    r.snz_armed = snz_on;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    item_t cmd;
    fire_result_t want;
    int i;
    if (!rst_n) begin
      for (i = 0; i < NUM_ALARMS; i++) alarms[i] = '0;
      fired_minute = '0;
      fired_valid = 1'b0;
      snz_on = 1'b0;
      snz_hour = '0;
      snz_minute = '0;
      delay = DELAY_W'(DELAY_RESET);
      fire_q.delete();
    end else begin
      // result first: it can never belong to a command taken at this edge
      if (out_tvalid && out_tready) begin
        if (fire_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, expected none, got kind %0d data %0h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = fire_q.pop_front();
          check_field("fire_kind", 8'(want.kind), 8'(out_tuser));
          check_field("fired_entry", 8'(want.entry), 8'(out_tdata[2:0]));
          check_field("snooze_due_now", 8'(want.due), 8'(out_tdata[3]));
          check_field("snooze_pending", 8'(want.snz_armed), 8'(out_tdata[4]));
        end
      end
      if (cfg_valid && cfg_ready) delay = cfg_data;
      if (in_tvalid && in_tready) begin
        cmd.opcode = opcode_t'(in_tuser);
        cmd.weekday = in_tdata[2:0];
        cmd.hour = in_tdata[7:3];
        cmd.minute = in_tdata[13:8];
        cmd.entry_index = in_tdata[16:14];
        cmd.entry_enable = in_tdata[17];
        cmd.day_mask = in_tdata[24:18];
        fire_q.push_back(predict_fire(cmd));
      end
    end
    pending <= fire_q.size();
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  import atm_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 321;
  // time pools, the first three of each are legal clock times
  localparam logic [19:0] HOUR_POOL = {5'd31, 5'd23, 5'd7, 5'd0};
  localparam logic [23:0] MINUTE_POOL = {6'd63, 6'd59, 6'd9, 6'd0};

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;

  int fail_count;
  int pending;
  int in_gap_max = 5;
  int out_stall_max = 5;
  int cur_delay = DELAY_RESET;

  alarm_table_matcher u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  atm_fire_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic item_t cmd_of(opcode_t op, int wd, int hr, int mn, int idx, int en,
                                   int mask);
    item_t c;
    c.opcode = op;
    c.weekday = WDAY_W'(wd);
    c.hour = HOUR_W'(hr);
    c.minute = MINUTE_W'(mn);
    c.entry_index = ENTRY_W'(idx);
    c.entry_enable = en[0];
    c.day_mask = MASK_W'(mask);
    return c;
  endfunction

  // mostly times from a small pool so that alarms and snoozes hit often
  function automatic item_t random_cmd();
    item_t c;
    int sel;
    int target;
    int base;
    c.weekday = WDAY_W'($urandom_range(0, 7));
    c.hour = HOUR_POOL[5 * $urandom_range(0, 3) +: 5];
    c.minute = MINUTE_POOL[6 * $urandom_range(0, 3) +: 6];
    if ($urandom_range(0, 9) == 0) begin
      c.hour = HOUR_W'($urandom);
      c.minute = MINUTE_W'($urandom);
    end
    c.entry_index = ENTRY_W'($urandom_range(0, 7));
    c.entry_enable = ($urandom_range(0, 4) != 0);
    c.day_mask = MASK_W'($urandom);
    if ($urandom_range(0, 5) == 0) c.day_mask = '0;
    else if ($urandom_range(0, 5) == 0) c.day_mask = '1;
    sel = $urandom_range(0, 19);
    if (sel < 11) begin
      c.opcode = OP_TICK;
    end else if (sel < 16) begin
      c.opcode = OP_WRITE;
    end else if (sel < 18) begin
      c.opcode = OP_ARM;
      // aim the snooze at a pool time the ticks will visit
      if ($urandom_range(0, 3) != 0) begin
        target = HOUR_POOL[5 * $urandom_range(0, 2) +: 5] * MIN_PER_HOUR +
                 MINUTE_POOL[6 * $urandom_range(0, 2) +: 6];
        base = (target - cur_delay % MIN_PER_DAY + MIN_PER_DAY) % MIN_PER_DAY;
        c.hour = HOUR_W'(base / MIN_PER_HOUR);
        c.minute = MINUTE_W'(base % MIN_PER_HOUR);
      end
    end else begin
      c.opcode = OP_CLEAR;
    end
    return c;
  endfunction

  task automatic send_cmd(input item_t c);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c.opcode;
    in_tdata <= {7'd0, c.day_mask, c.entry_enable, c.entry_index, c.minute, c.hour,
                 c.weekday};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_delay(input int value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= DELAY_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_delay = value;
  endtask

  // result side: random stall per transfer
  initial begin : sink
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int p;
    int n;
    int delays [PHASES];
    delays = '{0, 1439, 2047, 1, 9, 0};
    delays[PHASES-1] = $urandom_range(0, 2047);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset delay of nine
    send_cmd(cmd_of(OP_TICK, 0, 0, 0, 0, 0, 0));              // empty table
    send_cmd(cmd_of(OP_WRITE, 0, 7, 30, 0, 1, 7'b0000010));
    send_cmd(cmd_of(OP_TICK, 1, 7, 30, 0, 0, 0));             // alarm 0
    send_cmd(cmd_of(OP_TICK, 1, 7, 30, 0, 0, 0));             // same minute again
    send_cmd(cmd_of(OP_WRITE, 0, 7, 31, 3, 1, 7'h7f));
    send_cmd(cmd_of(OP_WRITE, 0, 7, 31, 5, 1, 0));            // one-off
    send_cmd(cmd_of(OP_TICK, 7, 7, 31, 0, 0, 0));             // weekday seven, one-off fires
    send_cmd(cmd_of(OP_WRITE, 0, 7, 32, 6, 1, 0));
    send_cmd(cmd_of(OP_TICK, 3, 7, 32, 0, 0, 0));
    send_cmd(cmd_of(OP_TICK, 7, 7, 31, 0, 0, 0));             // one-off now disabled
    send_cmd(cmd_of(OP_TICK, 0, 7, 31, 0, 0, 0));
    send_cmd(cmd_of(OP_WRITE, 0, 0, 4, 1, 1, 7'h7f));
    send_cmd(cmd_of(OP_ARM, 0, 23, 55, 0, 0, 0));             // wraps past midnight
    send_cmd(cmd_of(OP_TICK, 4, 0, 4, 0, 0, 0));              // snooze beats alarm
    send_cmd(cmd_of(OP_TICK, 4, 0, 4, 0, 0, 0));
    send_cmd(cmd_of(OP_WRITE, 0, 31, 63, 7, 1, 7'h7f));       // out of range time
    send_cmd(cmd_of(OP_WRITE, 0, 31, 63, 2, 0, 7'h7f));
    send_cmd(cmd_of(OP_TICK, 6, 31, 63, 0, 0, 0));
    send_cmd(cmd_of(OP_ARM, 0, 31, 63, 0, 0, 0));
    send_cmd(cmd_of(OP_CLEAR, 0, 8, 12, 0, 0, 0));            // due on a clear
    send_cmd(cmd_of(OP_WRITE, 0, 12, 0, 4, 1, 7'h7f));
    send_cmd(cmd_of(OP_WRITE, 0, 12, 0, 2, 1, 7'b0100000));
    send_cmd(cmd_of(OP_TICK, 5, 12, 0, 0, 0, 0));             // lowest index wins
    send_cmd(cmd_of(OP_WRITE, 0, 13, 0, 2, 1, 7'b0100000));
    send_cmd(cmd_of(OP_TICK, 4, 13, 0, 0, 0, 0));             // day not in mask

    for (p = 0; p < PHASES; p++) begin
      write_delay(delays[p]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) begin
          in_gap_max = 5 * $urandom_range(0, 1);
          out_stall_max = 5 * $urandom_range(0, 1);
        end
        send_cmd(random_cmd());
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
